### hw/rtl/paged_frame_allocator_defines.svh
// Assertion macros shared by the frame allocator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PAGED_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGED_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset
`define PAF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("paged_frame_allocator assertion failed");
// Checked on every edge, reset included
`define PAF_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("paged_frame_allocator assertion failed");
`else
`define PAF_ASSERT(name, prop)
`define PAF_ASSERT_ALWAYS(name, prop)
`endif

`endif

### hw/rtl/paf_pkg.sv
// Types and constants for the paged frame allocator.
// No dependencies.
`default_nettype none

package paf_pkg;

  // Field widths of items
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PID_W   = 4;
  localparam int unsigned BYTES_W = 20;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned FIDX_W  = 6;
  localparam int unsigned PCT_W   = 7;

  // Owner slots addressable by a process id, and tentative free count width
  localparam int unsigned ID_SLOTS = 16;
  localparam int unsigned TF_W     = 7;
  localparam int unsigned TF_MAX   = 127;
  localparam int unsigned PCT_SCALE = 100;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_EVICT = 2'd2
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_ROOM  = 2'd1,
    STS_NOT_HELD = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_A_OWN,
    S_A_MUL,
    S_A_CMP,
    S_A_FILL,
    S_F_CNT,
    S_E_MUL1,
    S_E_PROBE,
    S_E_OWN,
    S_E_TAIL,
    S_E_MUL2,
    S_E_DECIDE,
    S_E_RCNT,
    S_EMIT,
    S_SETTLE,
    S_REPLY
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/paged_frame_allocator.sv
// Paged frame allocator: frame owner table in a synchronous RAM with a registered read,
// used bits and eviction marks in flops. Uses paf_pkg and the assertion macros.
// Takes one item at a time and stalls input until it is done. Each table pass reads one
// entry per cycle through the single RAM read port unless an emit hold waits on an output
// stall; alloc scans owners then fills, free counts then emits, evict counts owners.
// Reset: used bits, marks and counters clear at once; no clearing pass.
`default_nettype none
`include "paged_frame_allocator_defines.svh"

module paged_frame_allocator #(
  parameter int unsigned NUM_FRAMES    = 64,
  parameter int unsigned FRAME_BYTES   = 4096,
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [paf_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [paf_pkg::PID_W-1:0]      process_id_i,
  input  wire logic [paf_pkg::BYTES_W-1:0]    memory_bytes_i,
  input  wire logic                           queue_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [paf_pkg::STS_W-1:0]           status_o,
  output logic                                frame_valid_o,
  output logic [paf_pkg::FIDX_W-1:0]          frame_index_o,
  output logic [paf_pkg::PID_W-1:0]           frame_owner_o,
  output logic                                last_o,
  output logic [paf_pkg::PCT_W-1:0]           usage_percent_o
);
  import paf_pkg::*;

  localparam int unsigned IDXW = $clog2(NUM_FRAMES);
  localparam int unsigned CNTW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned FBW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CAPW = TF_W + FBW;
  // usage = ((used*100 + N-1) * RECIP) >> SH, exact while (used*100+N-1)*N < 2^SH
  localparam int unsigned SH    = 20;
  localparam int unsigned RECIP = ((1 << SH) + NUM_FRAMES - 1) / NUM_FRAMES;
  localparam int unsigned K1    = PCT_SCALE * RECIP;
  localparam int unsigned K0    = (NUM_FRAMES - 1) * RECIP;
  localparam int unsigned PRODW = 40;

  localparam logic [CAPW-1:0] FB_C  = CAPW'(FRAME_BYTES);
  localparam logic [CNTW-1:0] NF_C  = CNTW'(NUM_FRAMES);

  // Control state
  state_e                state_q, state_d;
  logic [CNTW-1:0]       iss_q, iss_d;
  logic                  dat_vld_q, dat_vld_d;
  logic [IDXW-1:0]       dat_idx_q, dat_idx_d;
  logic [CNTW-1:0]       hits_q, hits_d;
  logic [NUM_FRAMES-1:0] used_q, used_d;
  logic [CNTW-1:0]       used_cnt_q, used_cnt_d;
  logic [ID_SLOTS-1:0]   mark_q, mark_d;
  logic [TF_W-1:0]       tf_q, tf_d;
  logic                  ev_act_q, ev_act_d;
  logic                  out_vld_q, out_vld_d;

  // Datapath registers
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [PID_W-1:0]      pid_q, pid_d;
  logic [BYTES_W-1:0]    bytes_q, bytes_d;
  logic                  qlast_q, qlast_d;
  logic [CAPW-1:0]       cap_q, cap_d;
  logic [CAPW-1:0]       acc_q, acc_d;
  status_e               reply_st_q, reply_st_d;
  logic [PCT_W-1:0]      usage_q;
  logic [STS_W-1:0]      out_sts_q, out_sts_d;
  logic                  out_fv_q, out_fv_d;
  logic [FIDX_W-1:0]     out_idx_q, out_idx_d;
  logic [PID_W-1:0]      out_own_q, out_own_d;
  logic                  out_last_q, out_last_d;
  logic [PCT_W-1:0]      out_pct_q, out_pct_d;

  // Owner table RAM
  logic [PID_W-1:0]      holder_mem [NUM_FRAMES];
  logic [PID_W-1:0]      holder_rd_q;
  logic [IDXW-1:0]       raddr;
  logic                  mem_we;
  logic [IDXW-1:0]       waddr;

  // Scan helpers
  logic                  in_pass, iss_more, pass_done, use_mark, hit, hold, out_free;
  logic                  pid_ok, mark_bit;
  logic [PID_W-1:0]      mark_idx;
  logic [CNTW-1:0]       free_cnt;
  logic [TF_W:0]         tf_sum;
  logic [PRODW-1:0]      usage_prod;

  assign out_free  = !out_vld_q || !out_stall_i;
  assign iss_more  = iss_q < NF_C;
  assign pid_ok    = 32'(pid_q) < MAX_PROCESSES;
  assign free_cnt  = NF_C - used_cnt_q;
  assign tf_sum    = (TF_W + 1)'(tf_q) + (TF_W + 1)'(hits_q);
  assign waddr     = iss_q[IDXW-1:0];

  assign in_pass = (state_q == S_A_OWN) || (state_q == S_F_CNT) || (state_q == S_E_OWN) ||
                   (state_q == S_E_RCNT) || (state_q == S_EMIT);
  assign use_mark = (state_q == S_E_RCNT) ||
                    ((state_q == S_EMIT) && (cmd_q == CMD_EVICT));
  assign pass_done = !iss_more && !dat_vld_q;

  // One mark read port: probed process, or owner of the scanned frame
  assign mark_idx = (state_q == S_E_PROBE) ? pid_q : holder_rd_q;
  assign mark_bit = mark_q[mark_idx];

  assign hit  = in_pass && dat_vld_q && used_q[dat_idx_q] &&
                (use_mark ? mark_bit : (holder_rd_q == pid_q));
  assign hold = (state_q == S_EMIT) && hit && !out_free;
  // On a hold the same entry is read again so its data stays in place
  assign raddr = hold ? dat_idx_q : iss_q[IDXW-1:0];

  // Usage percent, one constant multiply
  assign usage_prod = PRODW'(used_cnt_q) * PRODW'(K1) + PRODW'(K0);

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    dat_vld_d  = dat_vld_q;
    dat_idx_d  = dat_idx_q;
    hits_d     = hits_q;
    used_d     = used_q;
    used_cnt_d = used_cnt_q;
    mark_d     = mark_q;
    tf_d       = tf_q;
    ev_act_d   = ev_act_q;
    cmd_d      = cmd_q;
    pid_d      = pid_q;
    bytes_d    = bytes_q;
    qlast_d    = qlast_q;
    cap_d      = cap_q;
    acc_d      = acc_q;
    reply_st_d = reply_st_q;
    mem_we     = 1'b0;
    out_vld_d  = out_vld_q && out_stall_i;
    out_sts_d  = out_sts_q;
    out_fv_d   = out_fv_q;
    out_idx_d  = out_idx_q;
    out_own_d  = out_own_q;
    out_last_d = out_last_q;
    out_pct_d  = out_pct_q;

    // Table scan: issue one read a cycle unless an emit hold repeats it, act on the registered data
    if (in_pass) begin
      if (!hold) begin
        dat_vld_d = iss_more;
        dat_idx_d = iss_q[IDXW-1:0];
        if (iss_more) begin
          iss_d = iss_q + CNTW'(1);
        end
      end
      if (hit && (state_q != S_EMIT)) begin
        hits_d = hits_q + CNTW'(1);
      end
      if (hit && (state_q == S_EMIT) && out_free) begin
        used_d[dat_idx_q] = 1'b0;
        hits_d     = hits_q - CNTW'(1);
        out_vld_d  = 1'b1;
        out_sts_d  = STS_OK;
        out_fv_d   = 1'b1;
        out_idx_d  = FIDX_W'(dat_idx_q);
        out_own_d  = holder_rd_q;
        out_last_d = (hits_q == CNTW'(1));
        out_pct_d  = usage_q;
      end
    end else if (state_q != S_A_FILL) begin
      iss_d     = '0;
      dat_vld_d = 1'b0;
      hits_d    = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          pid_d   = process_id_i;
          bytes_d = memory_bytes_i;
          qlast_d = queue_last_i;
          state_d = S_START;
        end
      end
      S_START: begin
        case (cmd_q)
          CMD_ALLOC: begin
            mark_d   = '0;
            tf_d     = '0;
            ev_act_d = 1'b0;
            if (!pid_ok) begin
              reply_st_d = STS_NO_ROOM;
              state_d    = S_SETTLE;
            end else begin
              state_d = S_A_OWN;
            end
          end
          CMD_FREE: begin
            mark_d   = '0;
            tf_d     = '0;
            ev_act_d = 1'b0;
            if (!pid_ok) begin
              reply_st_d = STS_NOT_HELD;
              state_d    = S_SETTLE;
            end else begin
              state_d = S_F_CNT;
            end
          end
          CMD_EVICT: begin
            // First queue entry after idle opens a new eviction
            if (!ev_act_q) begin
              mark_d   = '0;
              tf_d     = TF_W'(free_cnt);
              ev_act_d = 1'b1;
            end
            state_d = S_E_MUL1;
          end
          default: begin
            reply_st_d = STS_OK;
            state_d    = S_SETTLE;
          end
        endcase
      end
      S_A_OWN: begin
        if (pass_done) begin
          if ((hits_q != '0) || (bytes_q == '0)) begin
            reply_st_d = STS_OK;
            state_d    = S_SETTLE;
          end else begin
            state_d = S_A_MUL;
          end
        end
      end
      S_A_MUL: begin
        cap_d   = CAPW'(free_cnt) * FB_C;
        state_d = S_A_CMP;
      end
      S_A_CMP: begin
        // need > free  <=>  bytes > free * FRAME_BYTES
        if (32'(bytes_q) > 32'(cap_q)) begin
          reply_st_d = STS_NO_ROOM;
          state_d    = S_SETTLE;
        end else begin
          acc_d   = '0;
          state_d = S_A_FILL;
        end
      end
      S_A_FILL: begin
        // Lowest free frames first, until granted bytes cover the request
        if (iss_more) begin
          if (!used_q[waddr] && (32'(acc_q) < 32'(bytes_q))) begin
            used_d[waddr] = 1'b1;
            mem_we        = 1'b1;
            used_cnt_d    = used_cnt_q + CNTW'(1);
            acc_d         = acc_q + FB_C;
          end
          iss_d = iss_q + CNTW'(1);
        end else begin
          reply_st_d = STS_OK;
          state_d    = S_SETTLE;
        end
      end
      S_F_CNT: begin
        if (pass_done) begin
          if (hits_q == '0) begin
            reply_st_d = STS_NOT_HELD;
            state_d    = S_SETTLE;
          end else begin
            used_cnt_d = used_cnt_q - hits_q;
            iss_d      = '0;
            state_d    = S_EMIT;
          end
        end
      end
      S_E_MUL1: begin
        cap_d   = CAPW'(tf_q) * FB_C;
        state_d = S_E_PROBE;
      end
      S_E_PROBE: begin
        // tentative_free < need, and the process not yet counted
        if ((32'(bytes_q) > 32'(cap_q)) && pid_ok && !mark_bit) begin
          state_d = S_E_OWN;
        end else begin
          state_d = S_E_TAIL;
        end
      end
      S_E_OWN: begin
        if (pass_done) begin
          if (hits_q != '0) begin
            mark_d[pid_q] = 1'b1;
            tf_d = (tf_sum > (TF_W + 1)'(TF_MAX)) ? TF_W'(TF_MAX) : TF_W'(tf_sum);
          end
          state_d = S_E_TAIL;
        end
      end
      S_E_TAIL: begin
        if (!qlast_q) begin
          reply_st_d = STS_OK;
          state_d    = S_SETTLE;
        end else begin
          state_d = S_E_MUL2;
        end
      end
      S_E_MUL2: begin
        cap_d   = CAPW'(tf_q) * FB_C;
        state_d = S_E_DECIDE;
      end
      S_E_DECIDE: begin
        if (32'(bytes_q) > 32'(cap_q)) begin
          mark_d     = '0;
          tf_d       = '0;
          ev_act_d   = 1'b0;
          reply_st_d = STS_NO_ROOM;
          state_d    = S_SETTLE;
        end else begin
          state_d = S_E_RCNT;
        end
      end
      S_E_RCNT: begin
        if (pass_done) begin
          if (hits_q == '0) begin
            mark_d     = '0;
            tf_d       = '0;
            ev_act_d   = 1'b0;
            reply_st_d = STS_OK;
            state_d    = S_SETTLE;
          end else begin
            used_cnt_d = used_cnt_q - hits_q;
            iss_d      = '0;
            state_d    = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (pass_done) begin
          if (cmd_q == CMD_EVICT) begin
            mark_d   = '0;
            tf_d     = '0;
            ev_act_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      S_SETTLE: begin
        // lets usage catch up with the final frame count
        state_d = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_sts_d  = reply_st_q;
          out_fv_d   = 1'b0;
          out_idx_d  = '0;
          out_own_d  = '0;
          out_last_d = 1'b1;
          out_pct_d  = usage_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      iss_q      <= '0;
      dat_vld_q  <= 1'b0;
      hits_q     <= '0;
      used_q     <= '0;
      used_cnt_q <= '0;
      mark_q     <= '0;
      tf_q       <= '0;
      ev_act_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_q      <= iss_d;
      dat_vld_q  <= dat_vld_d;
      hits_q     <= hits_d;
      used_q     <= used_d;
      used_cnt_q <= used_cnt_d;
      mark_q     <= mark_d;
      tf_q       <= tf_d;
      ev_act_q   <= ev_act_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dat_idx_q  <= dat_idx_d;
    cmd_q      <= cmd_d;
    pid_q      <= pid_d;
    bytes_q    <= bytes_d;
    qlast_q    <= qlast_d;
    cap_q      <= cap_d;
    acc_q      <= acc_d;
    reply_st_q <= reply_st_d;
    usage_q    <= usage_prod[SH +: PCT_W];
    out_sts_q  <= out_sts_d;
    out_fv_q   <= out_fv_d;
    out_idx_q  <= out_idx_d;
    out_own_q  <= out_own_d;
    out_last_q <= out_last_d;
    out_pct_q  <= out_pct_d;
  end

  // Owner table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      holder_mem[waddr] <= pid_q;
    end
    holder_rd_q <= holder_mem[raddr];
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_sts_q;
  assign frame_valid_o   = out_fv_q;
  assign frame_index_o   = out_idx_q;
  assign frame_owner_o   = out_own_q;
  assign last_o          = out_last_q;
  assign usage_percent_o = out_pct_q;

  // Between items the frame count matches the used bits
  `PAF_ASSERT(a_cnt_idle, (state_q == S_IDLE) |-> (used_cnt_q == CNTW'($countones(used_q))))
  // Marks only live inside an open eviction
  `PAF_ASSERT_ALWAYS(a_marks, !ev_act_q |-> (mark_q == '0))
  // Every released frame was counted in the preceding pass
  `PAF_ASSERT(a_emit_cnt, ((state_q == S_EMIT) && hit) |-> (hits_q != '0))
  // The emit pass ends with every counted frame delivered
  `PAF_ASSERT(a_emit_end, ((state_q == S_EMIT) && pass_done) |-> (hits_q == '0))

endmodule

`default_nettype wire
